@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the keystream cipher.
// Depends on nothing; simulation builds see checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define XKS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define XKS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define XKS_ASSERT(label, clk, rst_n, prop)

`define XKS_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/xks_pkg.sv @@
// Constants, types and helpers for the xorshift keystream byte cipher.
// Used by xks_mul64, xks_core and the top level; depends on nothing.
package xks_pkg;

	localparam int INDEX_WIDTH = 32;

	localparam logic [63:0] GOLDEN_CONST = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_CONST   = 64'h6A09_E667_F3BC_C909;
	localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
	localparam logic [63:0] OUT_MULT     = 64'h2545_F491_4F6C_DD1D;

	// configuration register map
	localparam int          NUM_REGS   = 6;
	localparam int          REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_KEY0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY1  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY2  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY3  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NONCE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TIME  = 3'd5;

	// seeding walks 48 bytes: key, nonce, timestamp
	localparam int SEED_BYTES = 48;
	localparam int SEED_CNT_W = 6;
	localparam logic [SEED_CNT_W-1:0] SEED_LAST = SEED_CNT_W'(SEED_BYTES - 1);

	typedef logic [NUM_REGS-1:0][63:0] cfg_regs_t;

	// core status toward the top level
	typedef struct packed {
		logic       idle;
		logic       res_valid;
		logic [7:0] res_byte;
	} xks_stat_t;

	function automatic logic [63:0] rotl13(input logic [63:0] v);
		rotl13 = {v[50:0], v[63:51]};
	endfunction

	function automatic logic [63:0] rotl17(input logic [63:0] v);
		rotl17 = {v[46:0], v[63:47]};
	endfunction

	function automatic logic [63:0] xorshift(input logic [63:0] v);
		logic [63:0] a;
		logic [63:0] b;
		a = v ^ (v >> 12);
		b = a ^ (a << 25);
		xorshift = b ^ (b >> 27);
	endfunction

endpackage

@@ hw/rtl/xorshift_keystream_byte_cipher_top.sv @@
// The core takes a new byte only once its last result has moved to the output
// register; a byte flagged first adds 48 seeding mix steps before its own step.
// Each step waits on the single 32x32 multiplier, which needs three passes for each
// 64-bit product. A finished byte may wait in the output register while the next
// byte is taken.
// Reset (arst_n low, asynchronous): registers, chain state and byte index go to zero.
module xorshift_keystream_byte_cipher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           first,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	input  logic                           wr_en,
	input  logic [xks_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [63:0]                    wr_data
);
	import xks_pkg::*;

	cfg_regs_t  regs_q;
	xks_stat_t  stat;
	logic       req_take;
	logic       res_take;
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	assign in_ready = stat.idle;
	assign req_take = in_valid && in_ready;
	assign res_take = stat.res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en && (32'(wr_index) < NUM_REGS)) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	xks_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_take),
		.data_byte (data_byte),
		.first     (first),
		.cfg       (regs_q),
		.res_take  (res_take),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_byte_q <= stat.res_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

@@ hw/rtl/xks_mul64.sv @@
// Low 64 bits of a 64 x 64 product built from one shared 32 x 32 multiplier.
// Three passes: low x low, low x high, high x low. Depends on xks_pkg.
module xks_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	import xks_pkg::*;

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	always_comb begin
		op_a = (cnt_q == STEP_HL) ? a_q[63:32] : a_q[31:0];
		op_b = (cnt_q == STEP_LH) ? b_q[63:32] : b_q[31:0];
		prod = 64'(op_a) * 64'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= STEP_LL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_LL;
			end else if (busy_q) begin
				if (cnt_q == STEP_HL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			// cross terms only reach the upper half
			if (cnt_q == STEP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

@@ hw/rtl/xks_core.sv @@
// Sequencer and datapath of the keystream cipher: seeding mix and per-byte step.
// Depends on xks_pkg, xks_mul64 and assert_macros.svh.
`include "assert_macros.svh"

module xks_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [7:0]          data_byte,
	input  logic                first,
	input  xks_pkg::cfg_regs_t  cfg,
	input  logic                res_take,
	output xks_pkg::xks_stat_t  stat
);
	import xks_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MIX_A  = 8'b0000_0010,
		ST_MIX_B  = 8'b0000_0100,
		ST_MIX_W  = 8'b0000_1000,
		ST_STEP_A = 8'b0001_0000,
		ST_STEP_B = 8'b0010_0000,
		ST_STEP_W = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [63:0]             s_q;
	logic [63:0]             tmp_q;
	logic [INDEX_WIDTH-1:0]  idx_q;
	logic [SEED_CNT_W-1:0]   k_q;
	logic [7:0]              data_q;
	logic [7:0]              res_q;

	logic [63:0] sel_word;
	logic [7:0]  seed_byte;
	logic [63:0] mix_x;
	logic [63:0] step_sum;
	logic        mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_p;
	logic [63:0] ks_word;

	always_comb begin
		sel_word  = cfg[k_q[5:3]];
		seed_byte = 8'(sel_word >> {k_q[2:0], 3'b000});
		mix_x     = s_q ^ (tmp_q + {56'd0, seed_byte} + GOLDEN_CONST);
		step_sum  = tmp_q + GOLDEN_CONST + 64'(idx_q);
		mul_start = (state_q == ST_MIX_B) || (state_q == ST_STEP_B);
		mul_a     = (state_q == ST_STEP_B) ? rotl17(step_sum) : rotl13(mix_x);
		mul_b     = (state_q == ST_STEP_B) ? OUT_MULT : FNV_PRIME;
		ks_word   = mul_p >> {idx_q[2:0], 3'b000};
	end

	xks_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			s_q     <= '0;
			idx_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (first) begin
							s_q     <= SEED_CONST ^ cfg[REG_TIME];
							idx_q   <= '0;
							k_q     <= '0;
							state_q <= ST_MIX_A;
						end else begin
							state_q <= ST_STEP_A;
						end
					end
				end
				ST_MIX_A: state_q <= ST_MIX_B;
				ST_MIX_B: state_q <= ST_MIX_W;
				ST_MIX_W: begin
					if (mul_done) begin
						s_q <= mul_p;
						if (k_q == SEED_LAST) begin
							k_q     <= '0;
							state_q <= ST_STEP_A;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_MIX_A;
						end
					end
				end
				ST_STEP_A: state_q <= ST_STEP_B;
				ST_STEP_B: state_q <= ST_STEP_W;
				ST_STEP_W: begin
					if (mul_done) begin
						s_q     <= mul_p;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			data_q <= data_byte;
		end
		// fold terms of the mix add, or the xorshift of the chain state
		if (state_q == ST_MIX_A) begin
			tmp_q <= (s_q << 6) + (s_q >> 2);
		end else if (state_q == ST_STEP_A) begin
			tmp_q <= xorshift(s_q);
		end
		if (state_q == ST_STEP_W && mul_done) begin
			res_q <= data_q ^ ks_word[7:0];
		end
	end

	assign stat.idle      = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_DONE);
	assign stat.res_byte  = res_q;

	`XKS_ASSERT(a_done_in_wait, clk, arst_n,
		mul_done |-> (state_q == ST_MIX_W || state_q == ST_STEP_W))
	`XKS_ASSERT(a_first_clears_idx, clk, arst_n,
		(state_q == ST_IDLE && start && first) |=> (idx_q == '0 && state_q == ST_MIX_A))
	`XKS_NEVER(a_seed_count_range, clk, arst_n,
		(state_q == ST_MIX_A || state_q == ST_MIX_W) && (k_q > SEED_LAST))
	`XKS_ASSERT(a_result_holds, clk, arst_n,
		(state_q == ST_DONE && !res_take) |=> (state_q == ST_DONE && $stable(res_q)))

endmodule

@@ tb/xks_stream_checker.sv @@
// Scoreboard for the xorshift keystream byte cipher: mirrors register writes,
// predicts each output byte from accepted requests and compares in order.
// Depends on xks_pkg for the register index width only.
`timescale 1ns / 100ps

module xks_stream_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          first,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    out_byte,
	input  logic                          wr_en,
	input  logic [xks_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [63:0]                   wr_data,
	output int                            pending,
	output int                            errors
);

	localparam logic [63:0] GOLDEN_ADD = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_BASE  = 64'h6A09_E667_F3BC_C909;
	localparam logic [63:0] FOLD_MUL   = 64'h0000_0100_0000_01B3;
	localparam logic [63:0] STREAM_MUL = 64'h2545_F491_4F6C_DD1D;
	localparam int          REG_COUNT  = 6;
	localparam int          TS_SLOT    = 5;

	logic [63:0] cfg_shadow [REG_COUNT];
	logic [63:0] chain_s;
	logic [31:0] chain_idx;
	logic [63:0] s_cur;
	logic [31:0] i_cur;
	logic [7:0]  want;
	logic [7:0]  out_byte_q [$];

	function automatic logic [63:0] rotate_left(input logic [63:0] v, input int k);
		return (v << k) | (v >> (64 - k));
	endfunction

	// fold the eight bytes of one word into the seed, low byte first
	function automatic logic [63:0] absorb_word(input logic [63:0] s, input logic [63:0] w);
		logic [63:0] t;
		int k;
		t = s;
		for (k = 0; k < 8; k++) begin
			t = t ^ ({56'd0, w[8*k +: 8]} + GOLDEN_ADD + (t << 6) + (t >> 2));
			t = rotate_left(t, 13) * FOLD_MUL;
		end
		return t;
	endfunction

	// key words, then nonce, then timestamp
	function automatic logic [63:0] derive_seed();
		logic [63:0] s;
		int w;
		s = SEED_BASE ^ cfg_shadow[TS_SLOT];
		for (w = 0; w < REG_COUNT; w++)
			s = absorb_word(s, cfg_shadow[w]);
		return s;
	endfunction

	function automatic logic [63:0] next_chain(input logic [63:0] s, input logic [31:0] idx);
		logic [63:0] t;
		t = s ^ (s >> 12);
		t = t ^ (t << 25);
		t = t ^ (t >> 27);
		return rotate_left(t + GOLDEN_ADD + {32'd0, idx}, 17) * STREAM_MUL;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] checker: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cfg_shadow[r])
				cfg_shadow[r] = '0;
			chain_s = '0;
			chain_idx = '0;
			out_byte_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			// outputs always belong to earlier requests, so check them first
			if (out_valid && out_ready) begin
				if (out_byte_q.size() == 0) begin
					report_mismatch($sformatf("out_byte %h with no request pending", out_byte));
				end else begin
					want = out_byte_q.pop_front();
					if (out_byte !== want)
						report_mismatch($sformatf("out_byte %h, predicted %h", out_byte, want));
				end
			end
			// drop writes to unused indices
			if (wr_en && wr_index < REG_COUNT)
				cfg_shadow[wr_index] = wr_data;
			if (in_valid && in_ready) begin
				if (first) begin
					s_cur = derive_seed();
					i_cur = '0;
				end else begin
					s_cur = chain_s;
					i_cur = chain_idx;
				end
				chain_s = next_chain(s_cur, i_cur);
				chain_idx = i_cur + 32'd1;
				out_byte_q.push_back(data_byte ^ chain_s[8*i_cur[2:0] +: 8]);
			end
			pending = out_byte_q.size();
		end
	end

endmodule

@@ tb/xorshift_keystream_byte_cipher_top_tb.sv @@
// Top-level bench for the keystream cipher: drives requests, register writes and
// output back-pressure, and reports the verdict from xks_stream_checker.
// Depends on xks_pkg, xks_stream_checker and the cipher RTL.
`timescale 1ns / 100ps

module xorshift_keystream_byte_cipher_top_tb;

	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int SETTLE_CYCLES = 16;

	localparam logic [xks_pkg::REG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [xks_pkg::REG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    data_byte;
	logic                          first;
	logic                          out_valid;
	logic                          out_ready;
	logic [7:0]                    out_byte;
	logic                          wr_en;
	logic [xks_pkg::REG_IDX_W-1:0] wr_index;
	logic [63:0]                   wr_data;

	int pending;
	int errors;
	int cycle_count = 0;
	int bytes_sent;
	bit no_idle = 1'b0;

	xorshift_keystream_byte_cipher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	xks_stream_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// output back-pressure: a random stall before each output
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk iff out_valid);
		end
	end

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// hold valid and payload until the request is taken
	task automatic send_byte(input logic [7:0] d, input logic f);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		first <= f;
		@(posedge clk iff in_ready);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [xks_pkg::REG_IDX_W-1:0] idx, input logic [63:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
	endtask

	task automatic close_writes();
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, then wait for every output to come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int n_msgs;
		int len;
		logic f;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		first = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		bytes_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// run from the reset state without any seeding
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		// seed from all-zero registers, twice in a row
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		for (int b = 0; b < 8; b++)
			send_byte(8'h01 << b, 1'b0);
		wait_drained();

		write_reg(xks_pkg::REG_KEY0, '1);
		write_reg(xks_pkg::REG_KEY1, '1);
		write_reg(xks_pkg::REG_KEY2, '1);
		write_reg(xks_pkg::REG_KEY3, '1);
		write_reg(xks_pkg::REG_NONCE, '1);
		write_reg(xks_pkg::REG_TIME, '1);
		write_reg(REG_SPARE6, {$urandom, $urandom});
		write_reg(REG_SPARE7, {$urandom, $urandom});
		close_writes();
		// new registers must not touch the running message
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		wait_drained();

		write_reg(xks_pkg::REG_KEY0, {$urandom, $urandom});
		write_reg(xks_pkg::REG_KEY1, '0);
		write_reg(xks_pkg::REG_KEY3, {$urandom, $urandom});
		write_reg(xks_pkg::REG_NONCE, {$urandom, $urandom});
		write_reg(xks_pkg::REG_TIME, {$urandom, $urandom});
		close_writes();
		send_byte(8'hC3, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);

		bytes_sent = 0;
		while (bytes_sent < RANDOM_ITEMS) begin
			wait_drained();
			no_idle = ($urandom_range(0, 3) == 0);
			for (int r = 0; r < 8; r++)
				if ($urandom_range(0, 2) == 0)
					write_reg(xks_pkg::REG_IDX_W'(r), pick_word());
			close_writes();
			n_msgs = $urandom_range(1, 4);
			for (int m = 0; m < n_msgs; m++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
					: $urandom_range(1, 24);
				// now and then carry the old message across the register writes
				f = (m == 0 && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
				send_byte(8'($urandom_range(0, 255)), f);
				for (int b = 1; b < len; b++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
			end
		end
		wait_drained();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
